// ----- sv/rqfs_pkg.sv -----
// Shared constants, codes and the entry type of the request queue.
package rqfs_pkg;

   // Store geometry.
   localparam int DEPTH   = 1024;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CHILD_W = IDX_W + 2;

   // Field widths of the ports.
   localparam int HANDLE_W = 16;
   localparam int TAG_W    = 16;
   localparam int SIZE_W   = 32;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 11;
   localparam int CSR_W    = 11;
   localparam int CSR_IDX_W = 1;

   // Item kinds.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Policies.
   localparam logic POL_FIFO     = 1'b0;
   localparam logic POL_SMALLEST = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'b1;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   // One stored request; the size is the heap key.
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [TAG_W-1:0]    name_tag;
      logic [SIZE_W-1:0]   size;
   } entry_type;

endpackage

// ----- sv/request_queue_fifo_or_smallest_first.sv -----
// Request queue holding entries in one store, as a FIFO or as a size-keyed min-heap.
//
//  Channel | Direction | Handshake             | Payload
//  req     | in        | req_valid / req_ready | kind, handle, name_tag, item_size
//  rsp     | out       | rsp_valid / rsp_ready | status, out_handle, out_name_tag, out_size
//  csr     | in        | csr_we                | csr_index, csr_wdata
//
// One item at a time, paced by the single read port of the store: a refused insert or a
// remove on empty goes straight to the result, a FIFO insert writes at the tail, a FIFO
// remove reads at the head, a heap insert reads one parent per level climbed, and a heap
// remove reads the root and the last entry, then both children per level descended.
// Reset clears the count, indexes, registers and handshake state; the store is kept.
// A stalled result is held in the output register while the next item is taken.
module request_queue_fifo_or_smallest_first (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [rqfs_pkg::HANDLE_W-1:0]   req_handle,
   input  logic [rqfs_pkg::TAG_W-1:0]      req_name_tag,
   input  logic [rqfs_pkg::SIZE_W-1:0]     req_item_size,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rqfs_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rqfs_pkg::HANDLE_W-1:0]   rsp_out_handle,
   output logic [rqfs_pkg::TAG_W-1:0]      rsp_out_name_tag,
   output logic [rqfs_pkg::SIZE_W-1:0]     rsp_out_size,
   input  logic                            csr_we,
   input  logic [rqfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rqfs_pkg::CSR_W-1:0]      csr_wdata
);
   import rqfs_pkg::*;

   // Sequencer states.
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_UP_CHK  = 4'd1;
   localparam logic [3:0] S_UP_CMP  = 4'd2;
   localparam logic [3:0] S_FIFO_RD = 4'd3;
   localparam logic [3:0] S_RM_ROOT = 4'd4;
   localparam logic [3:0] S_RM_LAST = 4'd5;
   localparam logic [3:0] S_DN_L    = 4'd6;
   localparam logic [3:0] S_DN_R    = 4'd7;
   localparam logic [3:0] S_DN_CMP  = 4'd8;
   localparam logic [3:0] S_OUT     = 4'd9;

   // Control registers.
   logic [3:0]       state_ff, state_in;
   logic             policy_ff, policy_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [IDX_W-1:0]    pos_ff, pos_in;
   entry_type           hole_ff, hole_in;
   entry_type           cand_ff, cand_in;
   logic                win_ff, win_in;
   logic                rv_ff, rv_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   entry_type           res_data_ff, res_data_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   entry_type           rsp_data_ff, rsp_data_in;

   // Store and its ports.
   entry_type        mem [DEPTH];
   entry_type        rd_data_ff;
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   entry_type        mem_wdata;

   // Derived values.
   logic [CNT_W-1:0]   limit;
   logic               full;
   entry_type          req_entry;
   logic [IDX_W-1:0]   pos_m1;
   logic [IDX_W-1:0]   parent_idx;
   logic [CHILD_W-1:0] l_idx, r_idx, count_ext;
   logic [CNT_W-1:0]   count_m1;
   logic               right_wins;
   logic               accept;

   // The limit in force is the smaller of capacity and the store depth.
   always_comb begin
      if (int'(cap_ff) < DEPTH) begin
         limit = CNT_W'(cap_ff);
      end else begin
         limit = CNT_W'(DEPTH);
      end
   end

   assign full       = (count_ff >= limit);
   assign req_entry  = {req_handle, req_name_tag, req_item_size};
   assign pos_m1     = pos_ff - 1'b1;
   assign parent_idx = pos_m1 >> 1;
   assign l_idx      = {1'b0, pos_ff, 1'b1};
   assign r_idx      = l_idx + 1'b1;
   assign count_ext  = CHILD_W'(count_ff);
   assign count_m1   = count_ff - 1'b1;
   assign right_wins = rv_ff && (rd_data_ff.size < cand_ff.size);
   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;

   // Store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // Sequencer: FIFO access, heap sift-up and sift-down with a moving hole.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      pos_in        = pos_ff;
      hole_in       = hole_ff;
      cand_in       = cand_ff;
      win_in        = win_ff;
      rv_in         = rv_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = hole_ff;
      mem_re        = 1'b0;
      mem_raddr     = pos_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_data_in = '0;
               if (req_kind == KIND_INSERT) begin
                  res_status_in = ST_INSERTED;
                  if (full) begin
                     res_status_in = ST_FULL;
                     state_in      = S_OUT;
                  end else if (policy_ff == POL_FIFO) begin
                     mem_we    = 1'b1;
                     mem_waddr = tail_ff;
                     mem_wdata = req_entry;
                     if (int'(tail_ff) == DEPTH - 1) begin
                        tail_in = '0;
                     end else begin
                        tail_in = tail_ff + 1'b1;
                     end
                     count_in = count_ff + 1'b1;
                     state_in = S_OUT;
                  end else begin
                     hole_in  = req_entry;
                     pos_in   = count_ff[IDX_W-1:0];
                     count_in = count_ff + 1'b1;
                     state_in = S_UP_CHK;
                  end
               end else begin
                  res_status_in = ST_REMOVED;
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_OUT;
                  end else if (policy_ff == POL_FIFO) begin
                     mem_re    = 1'b1;
                     mem_raddr = head_ff;
                     if (int'(head_ff) == DEPTH - 1) begin
                        head_in = '0;
                     end else begin
                        head_in = head_ff + 1'b1;
                     end
                     count_in = count_m1;
                     state_in = S_FIFO_RD;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = '0;
                     state_in  = S_RM_ROOT;
                  end
               end
            end
         end
         S_UP_CHK: begin
            // At the root the hole is final; otherwise fetch the parent.
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = S_OUT;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = parent_idx;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            // A strictly larger parent moves down into the hole.
            mem_we = 1'b1;
            if (hole_ff.size < rd_data_ff.size) begin
               mem_wdata = rd_data_ff;
               pos_in    = parent_idx;
               state_in  = S_UP_CHK;
            end else begin
               state_in = S_OUT;
            end
         end
         S_FIFO_RD: begin
            res_data_in = rd_data_ff;
            state_in    = S_OUT;
         end
         S_RM_ROOT: begin
            // The root is the result; the last entry becomes the moving element.
            res_data_in = rd_data_ff;
            count_in    = count_m1;
            if (count_m1 == '0) begin
               state_in = S_OUT;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = count_m1[IDX_W-1:0];
               state_in  = S_RM_LAST;
            end
         end
         S_RM_LAST: begin
            hole_in  = rd_data_ff;
            pos_in   = '0;
            state_in = S_DN_L;
         end
         S_DN_L: begin
            if (l_idx >= count_ext) begin
               mem_we   = 1'b1;
               state_in = S_OUT;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = l_idx[IDX_W-1:0];
               state_in  = S_DN_R;
            end
         end
         S_DN_R: begin
            // The left child wins only when strictly smaller than the hole element.
            win_in = (rd_data_ff.size < hole_ff.size);
            if (rd_data_ff.size < hole_ff.size) begin
               cand_in = rd_data_ff;
            end else begin
               cand_in = hole_ff;
            end
            rv_in = (r_idx < count_ext);
            if (r_idx < count_ext) begin
               mem_re    = 1'b1;
               mem_raddr = r_idx[IDX_W-1:0];
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            // The smallest child, if smaller, moves up and the hole descends.
            mem_we = 1'b1;
            if (right_wins) begin
               mem_wdata = rd_data_ff;
               pos_in    = r_idx[IDX_W-1:0];
               state_in  = S_DN_L;
            end else if (win_ff) begin
               mem_wdata = cand_ff;
               pos_in    = l_idx[IDX_W-1:0];
               state_in  = S_DN_L;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loaded from the finished result when free or being taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_data_in   = res_data_ff;
      end
   end

   // Register writes.
   always_comb begin
      policy_in = policy_ff;
      cap_in    = cap_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY:   policy_in = csr_wdata[0];
            CSR_CAPACITY: cap_in    = csr_wdata[CAP_W-1:0];
            default:      ;
         endcase
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         policy_ff    <= POL_FIFO;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      hole_ff       <= hole_in;
      cand_ff       <= cand_in;
      win_ff        <= win_in;
      rv_ff         <= rv_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_handle   = rsp_data_ff.handle;
   assign rsp_out_name_tag = rsp_data_ff.name_tag;
   assign rsp_out_size     = rsp_data_ff.size;

   // The count never exceeds the store depth.
   assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= DEPTH)
      else $error("entry count beyond store depth");

   // A read never meets a write to the same entry in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write of the same entry in one cycle");

   // An accepted item always leaves the idle state.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted item did not start");

   // Only a removed entry carries data in the result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_REMOVED) |-> (rsp_data_ff == '0))
      else $error("result data not zero for a non-remove status");

   // An insert that is accepted and not refused leaves the count one higher when it starts.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_INSERT && !full) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("count not advanced on an accepted insert");

endmodule
